// ----- design/itoa_pkg.sv -----
// Shared constants and control types for the integer-to-decimal formatter.
// No dependencies; every other design file refers to this package by scope.
package itoa_pkg;

  localparam int ValueW    = 32;
  localparam int DigitW    = 4;
  localparam int NumDigits = 10;
  localparam int BcdW      = NumDigits * DigitW;
  localparam int CntW      = $clog2(ValueW);
  localparam int DigCntW   = $clog2(NumDigits + 1);
  localparam int CharW     = 6;

  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  // Commands from the sequencer to the converter.
  typedef struct packed {
    logic load;    // capture a new magnitude, start conversion
    logic dshift;  // drop the top BCD digit, shift the rest up
  } conv_ctrl_t;

  // Converter status back to the sequencer.
  typedef struct packed {
    logic              busy;
    logic [DigitW-1:0] top_digit;
  } conv_stat_t;

endpackage

// ----- design/itoa_if.sv -----
// Valid/ready channel interfaces: integer input and character output.
// Depends on itoa_pkg for field widths.
interface itoa_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [itoa_pkg::ValueW-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itoa_out_if;
  logic                        valid;
  logic                        ready;
  logic [itoa_pkg::CharW-1:0]  char_code;
  logic                        last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

// ----- design/itoa_bcd_conv.sv -----
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Depends on itoa_pkg. Also shifts finished digits out, most significant first.
module itoa_bcd_conv (
  input  logic                          clk,
  input  logic                          rst,
  input  itoa_pkg::conv_ctrl_t          ctrl,
  input  logic [itoa_pkg::ValueW-1:0]   mag_in,
  output itoa_pkg::conv_stat_t          stat
);

  logic [itoa_pkg::ValueW-1:0] mag;
  logic [itoa_pkg::BcdW-1:0]   bcd;
  logic [itoa_pkg::BcdW-1:0]   bcd_adj;
  logic [itoa_pkg::CntW-1:0]   cnt;
  logic                        busy;

  // Add 3 to each digit of 5 or more before the shift.
  always_comb begin
    for (int i = 0; i < itoa_pkg::NumDigits; i++) begin
      if (bcd[i*itoa_pkg::DigitW +: itoa_pkg::DigitW] >= 4'd5) begin
        bcd_adj[i*itoa_pkg::DigitW +: itoa_pkg::DigitW] =
          bcd[i*itoa_pkg::DigitW +: itoa_pkg::DigitW] + 4'd3;
      end else begin
        bcd_adj[i*itoa_pkg::DigitW +: itoa_pkg::DigitW] =
          bcd[i*itoa_pkg::DigitW +: itoa_pkg::DigitW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctrl.load) begin
      mag  <= mag_in;
      bcd  <= '0;
      cnt  <= '0;
      busy <= 1'b1;
    end else if (busy) begin
      mag <= {mag[itoa_pkg::ValueW-2:0], 1'b0};
      bcd <= {bcd_adj[itoa_pkg::BcdW-2:0], mag[itoa_pkg::ValueW-1]};
      cnt <= cnt + 1'b1;
      if (cnt == itoa_pkg::CntW'(itoa_pkg::ValueW - 1)) begin
        busy <= 1'b0;
      end
    end else if (ctrl.dshift) begin
      bcd <= {bcd[itoa_pkg::BcdW-itoa_pkg::DigitW-1:0], {itoa_pkg::DigitW{1'b0}}};
    end
  end

  assign stat.busy      = busy;
  assign stat.top_digit = bcd[itoa_pkg::BcdW-1 -: itoa_pkg::DigitW];

endmodule

// ----- design/signed_int_to_decimal_ascii_core.sv -----
// Signed 32-bit integer to decimal ASCII, one character per output transfer.
// An input transfer starts the converter; the sequencer waits until it is done, drops
// leading zeros, then loads a '-' if negative and each digit into the output register.
// A new number is accepted only in idle, once the last digit of the previous is loaded;
// skipped and emitted digits always total ten. A stalled output holds the sequencer.
// Sync reset clears sequencer, converter busy and output valid; payload regs not reset.
module signed_int_to_decimal_ascii_core (
  input  logic              clk,
  input  logic              rst,
  itoa_in_if.sink           number,
  itoa_out_if.source        chars
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,   // converter running
    S_SKIP,   // drop leading zero digits
    S_SIGN,   // emit '-'
    S_EMIT    // emit digits, most significant first
  } state_t;

  state_t                            state;
  logic                              neg;
  logic [itoa_pkg::DigCntW-1:0]      dig_left;   // digits still in the BCD register
  logic [itoa_pkg::ValueW-1:0]       raw;
  logic [itoa_pkg::ValueW-1:0]       mag_in;
  logic                              accept;
  logic                              slot_free;  // output register can take a char
  logic                              out_load;   // a char enters the output register
  logic                              out_valid;
  logic [itoa_pkg::CharW-1:0]        out_char;
  logic                              out_last;
  itoa_pkg::conv_ctrl_t              ctrl;
  itoa_pkg::conv_stat_t              stat;

  assign raw    = number.value;
  // Two's complement magnitude; the most negative value maps to 2^31 unsigned.
  assign mag_in = raw[itoa_pkg::ValueW-1] ? (~raw + 1'b1) : raw;

  assign number.ready = (state == S_IDLE);
  assign accept       = number.valid && number.ready;
  assign slot_free    = !out_valid || chars.ready;
  assign out_load     = slot_free && (state == S_SIGN || state == S_EMIT);

  // Sequencer commands to the converter.
  always_comb begin
    ctrl.load   = accept;
    ctrl.dshift = 1'b0;
    unique case (state)
      S_SKIP:  ctrl.dshift = (stat.top_digit == '0) && (dig_left != 1);
      S_EMIT:  ctrl.dshift = slot_free;
      default: ctrl.dshift = 1'b0;
    endcase
  end

  itoa_bcd_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (ctrl),
    .mag_in (mag_in),
    .stat   (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      dig_left  <= '0;
      neg       <= 1'b0;
    end else begin
      // A new char keeps the register full; otherwise a transfer empties it.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (chars.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            neg   <= raw[itoa_pkg::ValueW-1];
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (!stat.busy) begin
            dig_left <= itoa_pkg::DigCntW'(itoa_pkg::NumDigits);
            state    <= S_SKIP;
          end
        end
        S_SKIP: begin
          // Zero keeps its last digit, so it prints as a single '0'.
          if (ctrl.dshift) begin
            dig_left <= dig_left - 1'b1;
          end else if (neg) begin
            state <= S_SIGN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_SIGN: begin
          if (slot_free) begin
            out_char  <= itoa_pkg::CharMinus;
            out_last  <= 1'b0;
            state     <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            out_char  <= itoa_pkg::CharZero + itoa_pkg::CharW'(stat.top_digit);
            out_last  <= (dig_left == 1);
            dig_left  <= dig_left - 1'b1;
            if (dig_left == 1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign chars.valid     = out_valid;
  assign chars.char_code = out_char;
  assign chars.last      = out_last;

`ifndef NO_ASSERTIONS
  a_accept_starts_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_CONV && stat.busy))
    else $error("accepted number did not start conversion");

  a_conv_only_in_conv: assert property (@(posedge clk) disable iff (rst)
    stat.busy |-> (state == S_CONV))
    else $error("converter busy outside conversion state");

  a_final_digit_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && slot_free && dig_left == 1) |=>
      (state == S_IDLE && chars.valid && chars.last))
    else $error("final digit not flagged last");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    (chars.valid && chars.char_code != itoa_pkg::CharMinus) |->
      (chars.char_code >= itoa_pkg::CharZero &&
       chars.char_code <= itoa_pkg::CharZero + 6'd9))
    else $error("character outside digit range");
`endif

endmodule
